// ===== hdl/rclc_pkg.sv =====
package rclc_pkg;

   // Fragment table geometry. The table is indexed by the low bits of the
   // sequence number, so the entry count must be a power of two.
   localparam int SEQ_ENTRIES = 256;
   localparam int SLOT_WIDTH  = $clog2(SEQ_ENTRIES);

   localparam int COUNT_WIDTH = 8;
   localparam int SECS_WIDTH  = 8;
   localparam int LEN_WIDTH   = 12;
   localparam int BYTE_WIDTH  = 8;

   // Configuration port geometry.
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic REG_KEEPALIVE = 1'b0;
   localparam logic REG_RECONNECT = 1'b1;

   localparam logic [SECS_WIDTH-1:0] KEEPALIVE_RESET = 8'd30;
   localparam logic [SECS_WIDTH-1:0] RECONNECT_RESET = 8'd45;
   localparam logic [SECS_WIDTH-1:0] IDLE_SATURATED  = 8'hFF;

   // A fragment header needs more than this many bytes in the datagram.
   localparam logic [LEN_WIDTH-1:0] FRAGMENT_MIN_LEN = 12'd9;

   localparam logic [BYTE_WIDTH-1:0] LOGIN_STATUS_OK = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] MARKER_MULTIPART = 8'h00;

   typedef enum logic [1:0] {
      MODE_DATAGRAM = 2'd0,
      MODE_TIMEOUT  = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [BYTE_WIDTH-1:0] {
      PKT_LOGIN   = 8'h00,
      PKT_COMMAND = 8'h01,
      PKT_MESSAGE = 8'h02
   } packet_type_type;

   typedef enum logic [3:0] {
      ACT_NONE         = 4'd0,
      ACT_LOGIN_OK     = 4'd1,
      ACT_LOGIN_REJECT = 4'd2,
      ACT_CMD_ACK      = 4'd3,
      ACT_FRAGMENT     = 4'd4,
      ACT_COMPLETE     = 4'd5,
      ACT_CHAT_ACK     = 4'd6,
      ACT_KEEPALIVE    = 4'd7,
      ACT_RECONNECT    = 4'd8
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

endpackage

// ===== hdl/rclc_req_if.sv =====
interface rclc_req_if;
   import rclc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [BYTE_WIDTH-1:0] packet_type;
   logic [BYTE_WIDTH-1:0] status_or_seq;
   logic [BYTE_WIDTH-1:0] marker_byte;
   logic [BYTE_WIDTH-1:0] parts_total;
   logic [BYTE_WIDTH-1:0] part_index;
   logic [LEN_WIDTH-1:0]  datagram_length;

   modport source (
      output valid, mode, packet_type, status_or_seq, marker_byte, parts_total,
             part_index, datagram_length,
      input  ready
   );

   modport sink (
      input  valid, mode, packet_type, status_or_seq, marker_byte, parts_total,
             part_index, datagram_length,
      output ready
   );
endinterface

// ===== hdl/rclc_rsp_if.sv =====
interface rclc_rsp_if;
   import rclc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [3:0]            action;
   logic [BYTE_WIDTH-1:0] ack_seq;
   logic                  link_up;

   modport source (
      output valid, action, ack_seq, link_up,
      input  ready
   );

   modport sink (
      input  valid, action, ack_seq, link_up,
      output ready
   );
endinterface

// ===== hdl/rclc_ram.sv =====
module rclc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/remote_console_link_controller.sv =====
// Client-side controller for a UDP remote-console link. Each word on the
// request channel is one event: the classified header of a received datagram,
// a receive timeout, or a one-second tick. For every accepted word the block
// returns exactly one word on the response channel carrying the chosen action
// (login ok or rejected, command ack, fragment stored, multipart complete,
// chat ack, keepalive, reconnect, or none), the sequence number to echo, and
// the logged-in flag after the event. Each event is evaluated in an accept
// step and a commit step: the accepting edge starts a read of the
// fragment-count memory, and the commit edge evaluates the event, writes the
// count back and loads the response register. That memory has a single,
// registered read port; a held response delays the evaluate step until it is
// taken, and no new word is accepted until the previous one has committed. The
// keepalive and reconnect thresholds sit at byte addresses 0 and 4 of the
// configuration port, reset to 30 and 45 seconds, and should only be written while no event is in flight.
module remote_console_link_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   rclc_req_if.sink                              req_chan,
   rclc_rsp_if.source                            rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rclc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [rclc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [rclc_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import rclc_pkg::*;

   // Configuration registers.
   logic [SECS_WIDTH-1:0] keepalive_ff, keepalive_in;
   logic [SECS_WIDTH-1:0] reconnect_ff, reconnect_in;
   logic                  csr_write;
   logic                  csr_index;

   // Control state.
   ctrl_state_type state_ff, state_in;
   logic           link_ff, link_in;
   logic [SECS_WIDTH-1:0]  idle_ff, idle_in;
   logic [SEQ_ENTRIES-1:0] active_ff, active_in;

   // The accepted event is held here while the memory read completes.
   logic [1:0]             mode_ff;
   logic [BYTE_WIDTH-1:0]  ptype_ff;
   logic [BYTE_WIDTH-1:0]  seq_ff;
   logic [BYTE_WIDTH-1:0]  marker_ff;
   logic [BYTE_WIDTH-1:0]  total_ff;
   logic [LEN_WIDTH-1:0]   len_ff;

   // Response register.
   logic                   out_valid_ff, out_valid_in;
   action_type             out_action_ff, out_action_in;
   logic [BYTE_WIDTH-1:0]  out_ack_ff, out_ack_in;
   logic                   out_link_ff;

   // Handshake and datapath signals.
   logic                   accept;
   logic                   commit;
   logic [SLOT_WIDTH-1:0]  slot;
   logic                   slot_active;
   logic [COUNT_WIDTH-1:0] count_rd;
   logic [COUNT_WIDTH-1:0] count_new;
   logic                   count_wr;
   logic                   multipart;
   logic                   complete;

   //------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is
   // tied high so no access is ever extended by wait states.
   //------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1];

   always_comb begin
      keepalive_in = keepalive_ff;
      reconnect_in = reconnect_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_KEEPALIVE: keepalive_in = pwdata[SECS_WIDTH-1:0];
            REG_RECONNECT: reconnect_in = pwdata[SECS_WIDTH-1:0];
            default:       keepalive_in = keepalive_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEEPALIVE: prdata = {{(CSR_DATA_WIDTH-SECS_WIDTH){1'b0}}, keepalive_ff};
         REG_RECONNECT: prdata = {{(CSR_DATA_WIDTH-SECS_WIDTH){1'b0}}, reconnect_ff};
         default:       prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Handshakes. Only one event is in flight at a time, so a memory write
   // always lands before the next read of any entry and no forwarding path
   // is needed.
   //------------------------------------------------------------------
   assign accept = req_chan.valid && req_chan.ready;
   assign commit = (state_ff == ST_EXEC) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = commit ? ST_IDLE : ST_EXEC;
         default: state_in = ST_IDLE;
      endcase
   end

   // No word is taken while reset is held, since it would be dropped.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: req_chan.ready = !reset;
         ST_EXEC: req_chan.ready = 1'b0;
         default: req_chan.ready = 1'b0;
      endcase
   end

   //------------------------------------------------------------------
   // Fragment table. Counts live in the memory; the valid bits live in
   // flip-flops so that reset clears every sequence at once. A count is
   // only ever used while its valid bit is set; otherwise counting restarts at one.
   //------------------------------------------------------------------
   assign slot        = seq_ff[SLOT_WIDTH-1:0];
   assign slot_active = active_ff[slot];

   rclc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (SEQ_ENTRIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr),
      .wr_addr (slot),
      .wr_data (count_new),
      .rd_en   (accept),
      .rd_addr (req_chan.status_or_seq[SLOT_WIDTH-1:0]),
      .rd_data (count_rd)
   );

   assign multipart = (marker_ff == MARKER_MULTIPART) && (len_ff > FRAGMENT_MIN_LEN);
   assign count_new = slot_active ? count_rd + COUNT_WIDTH'(1) : COUNT_WIDTH'(1);
   assign complete  = (count_new == total_ff);

   //------------------------------------------------------------------
   // Event evaluation. The evaluation block below takes effect only on the
   // commit edge, when the response register is free to take the result.
   //------------------------------------------------------------------
   always_comb begin
      link_in       = link_ff;
      idle_in       = idle_ff;
      active_in     = active_ff;
      count_wr      = 1'b0;
      out_action_in = ACT_NONE;
      out_ack_in    = '0;

      if (commit) begin
         unique case (mode_ff)
            MODE_DATAGRAM: begin
               unique case (ptype_ff)
                  PKT_LOGIN: begin
                     if (seq_ff == LOGIN_STATUS_OK) begin
                        link_in       = 1'b1;
                        idle_in       = '0;
                        out_action_in = ACT_LOGIN_OK;
                     end else begin
                        link_in       = 1'b0;
                        out_action_in = ACT_LOGIN_REJECT;
                     end
                  end
                  PKT_COMMAND: begin
                     // Replies that arrive while logged out are dropped.
                     if (link_ff) begin
                        idle_in = '0;
                        if (!multipart) begin
                           out_action_in = ACT_CMD_ACK;
                        end else begin
                           count_wr = 1'b1;
                           // A message whose count reaches its total frees
                           // the entry; this includes a single-part message.
                           active_in[slot] = !complete;
                           if (complete) begin
                              out_action_in = ACT_COMPLETE;
                              out_ack_in    = seq_ff;
                           end else begin
                              out_action_in = ACT_FRAGMENT;
                           end
                        end
                     end
                  end
                  PKT_MESSAGE: begin
                     idle_in = '0;
                     // A server message while logged out restores the link
                     // silently; otherwise it is acknowledged.
                     if (!link_ff) begin
                        link_in = 1'b1;
                     end else begin
                        out_action_in = ACT_CHAT_ACK;
                        out_ack_in    = seq_ff;
                     end
                  end
                  default: out_action_in = ACT_NONE;
               endcase
            end
            MODE_TIMEOUT: begin
               // Reconnect takes precedence over keepalive.
               priority if (idle_ff >= reconnect_ff) begin
                  idle_in       = '0;
                  link_in       = 1'b0;
                  out_action_in = ACT_RECONNECT;
               end else if (idle_ff >= keepalive_ff) begin
                  idle_in       = '0;
                  out_action_in = ACT_KEEPALIVE;
               end else begin
                  out_action_in = ACT_NONE;
               end
            end
            MODE_TICK: begin
               if (idle_ff != IDLE_SATURATED) begin
                  idle_in = idle_ff + SECS_WIDTH'(1);
               end
            end
            default: out_action_in = ACT_NONE;
         endcase
      end
   end

   always_comb begin
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   //------------------------------------------------------------------
   // Registers.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         keepalive_ff <= KEEPALIVE_RESET;
         reconnect_ff <= RECONNECT_RESET;
         state_ff     <= ST_IDLE;
         link_ff      <= 1'b0;
         idle_ff      <= '0;
         active_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         keepalive_ff <= keepalive_in;
         reconnect_ff <= reconnect_in;
         state_ff     <= state_in;
         link_ff      <= link_in;
         idle_ff      <= idle_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_chan.mode;
         ptype_ff  <= req_chan.packet_type;
         seq_ff    <= req_chan.status_or_seq;
         marker_ff <= req_chan.marker_byte;
         total_ff  <= req_chan.parts_total;
         len_ff    <= req_chan.datagram_length;
      end
      if (commit) begin
         out_action_ff <= out_action_in;
         out_ack_ff    <= out_ack_in;
         out_link_ff   <= link_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.action  = out_action_ff;
   assign rsp_chan.ack_seq = out_ack_ff;
   assign rsp_chan.link_up = out_link_ff;

endmodule

// ===== hdl/rclc_checker.sv =====
module rclc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [3:0]                        rsp_action,
   input logic [rclc_pkg::BYTE_WIDTH-1:0]   rsp_ack_seq,
   input logic                              rsp_link_up
);
   import rclc_pkg::*;

   // A held response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_ack_seq) && $stable(rsp_link_up))
      else $error("response changed while stalled");

   // Only completions and chat acks echo a sequence number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_action == ACT_COMPLETE || rsp_action == ACT_CHAT_ACK)
         |-> rsp_ack_seq == '0)
      else $error("sequence echoed for an action that carries none");

   // Actions that need a live session report the link as up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_LOGIN_OK || rsp_action == ACT_CMD_ACK
         || rsp_action == ACT_FRAGMENT || rsp_action == ACT_COMPLETE
         || rsp_action == ACT_CHAT_ACK) |-> rsp_link_up)
      else $error("session action reported with link down");

   // A rejected login or a reconnect drops the link.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_LOGIN_REJECT || rsp_action == ACT_RECONNECT)
         |-> !rsp_link_up)
      else $error("link still up after rejection or reconnect");

endmodule

bind remote_console_link_controller rclc_checker u_rclc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_action  (rsp_chan.action),
   .rsp_ack_seq (rsp_chan.ack_seq),
   .rsp_link_up (rsp_chan.link_up)
);
